FILE: rtl/kle_pkg.sv
// Shared constants and register indexes for the keystroke line editor.
package kle_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int IDX_W         = $clog2(LINE_CAPACITY);
  localparam int LEN_W         = 6;
  localparam int CHAR_W        = 8;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BACKSPACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT     = 2'd2;

  localparam logic [CHAR_W-1:0] BACKSPACE_RESET = 8'd8;
  localparam logic [CHAR_W-1:0] LEFT_RESET      = 8'd75;
  localparam logic [CHAR_W-1:0] RIGHT_RESET     = 8'd77;

  localparam logic [CHAR_W-1:0] PRINT_LIMIT = 8'h80;
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_CHAR   = 1'b1;

endpackage

FILE: rtl/kle_key_if.sv
// Keystroke / start channel.
interface kle_key_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [kle_pkg::CHAR_W-1:0]  key_code;
  logic                        control_key;
  logic [kle_pkg::LEN_W-1:0]   line_limit;
  logic [kle_pkg::CHAR_W-1:0]  end_char;

  modport source (output valid, op, key_code, control_key, line_limit, end_char,
                  input ready);
  modport sink   (input valid, op, key_code, control_key, line_limit, end_char,
                  output ready);
endinterface

FILE: rtl/kle_res_if.sv
// Result channel: status and line characters.
interface kle_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kle_pkg::CHAR_W-1:0]  char_value;
  logic [kle_pkg::LEN_W-1:0]   cursor_at;
  logic [kle_pkg::LEN_W-1:0]   text_len;
  logic [kle_pkg::LEN_W-1:0]   echo_len;
  logic                        edited;
  logic                        last;

  modport source (output valid, kind, char_value, cursor_at, text_len, echo_len,
                  edited, last, input ready);
  modport sink   (input valid, kind, char_value, cursor_at, text_len, echo_len,
                  edited, last, output ready);
endinterface

FILE: rtl/keystroke_line_editor.sv
// Keystroke line editor top level: line store, edit sequencer, result register.
//
//  channel  dir  transaction
//  key      in   op, key_code, control_key, line_limit, end_char
//  res      out  kind, char_value, cursor_at, text_len, echo_len, edited, last
//  cfg      in   write of backspace/left/right codes (cfg_we, cfg_idx, cfg_data)
//
// Insert and backspace shift the characters to the right of the cursor one at
// a time: up to 62 characters pass the store's one read port and one write
// port. Finishing a read of L > 0 characters streams one per cycle after a
// lead-in read, while the result channel is not stalled.
// Reset clears the control registers; the store itself is not cleared.
// The key channel is taken only between transactions; a stalled result just
// holds the sequencer in its status or emit state.
module keystroke_line_editor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kle_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kle_pkg::CHAR_W-1:0]     cfg_data,
  kle_key_if.sink                        key,
  kle_res_if.source                      res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SHL  = 3'd2;
  localparam logic [2:0] S_SHR  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;

  localparam int LW = kle_pkg::LEN_W;
  localparam int CW = kle_pkg::CHAR_W;
  localparam int AW = kle_pkg::IDX_W;

  // configuration
  logic [CW-1:0] backspace_code, left_code, right_code;

  // edit state
  logic [2:0]    state, state_next;
  logic [LW-1:0] line_length, line_length_next;
  logic [LW-1:0] cursor, cursor_next;
  logic [LW-1:0] longest_length, longest_length_next;
  logic [LW-1:0] length_limit, length_limit_next;
  logic [CW-1:0] terminator, terminator_next;
  logic          active, active_next;
  logic [LW-1:0] ptr, ptr_next;
  logic          edited, edited_next;

  // latched transaction
  logic          k_op;
  logic [CW-1:0] k_key;
  logic          k_ctl;
  logic [LW-1:0] k_limit;
  logic [CW-1:0] k_end;

  // line store
  logic [CW-1:0] line_store [kle_pkg::LINE_CAPACITY];
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] wr_data, rdata;
  logic          rdv, rdv_next;
  logic [AW-1:0] rd_idx;

  // result register
  logic          out_v, out_v_next;
  logic          out_load;
  logic          out_kind_next, out_edited_next, out_last_next;
  logic [CW-1:0] out_char_next;
  logic          out_kind, out_edited, out_last;
  logic [CW-1:0] out_char;
  logic [LW-1:0] out_cur, out_len, out_long;
  logic          out_free;
  logic          emit_move;

  assign key.ready = (state == S_IDLE);
  assign out_free  = !out_v || res.ready;
  assign emit_move = (state == S_EMIT) && rdv && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      backspace_code <= kle_pkg::BACKSPACE_RESET;
      left_code      <= kle_pkg::LEFT_RESET;
      right_code     <= kle_pkg::RIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        kle_pkg::REG_BACKSPACE: backspace_code <= cfg_data;
        kle_pkg::REG_LEFT:      left_code      <= cfg_data;
        kle_pkg::REG_RIGHT:     right_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (key.valid && key.ready) begin
      k_op    <= key.op;
      k_key   <= key.key_code;
      k_ctl   <= key.control_key;
      k_limit <= key.line_limit;
      k_end   <= key.end_char;
    end
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) line_store[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata  <= line_store[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  always_comb begin
    state_next          = state;
    line_length_next    = line_length;
    cursor_next         = cursor;
    longest_length_next = longest_length;
    length_limit_next   = length_limit;
    terminator_next     = terminator;
    active_next         = active;
    ptr_next            = ptr;
    edited_next         = edited;
    rdv_next            = 1'b0;
    rd_en               = 1'b0;
    rd_addr             = ptr[AW-1:0];
    wr_en               = 1'b0;
    wr_addr             = rd_idx - AW'(1);
    wr_data             = rdata;
    out_load            = 1'b0;
    out_kind_next       = kle_pkg::KIND_STATUS;
    out_char_next       = '0;
    out_edited_next     = edited;
    out_last_next       = 1'b1;

    case (state)
      S_IDLE: begin
        if (key.valid) state_next = S_EXEC;
      end

      S_EXEC: begin
        edited_next = 1'b1;
        state_next  = S_STAT;
        if (k_op == kle_pkg::OP_START) begin
          edited_next = 1'b0;
          if (!active) begin
            length_limit_next   = (int'(k_limit) > kle_pkg::LINE_CAPACITY - 1) ?
                                  LW'(kle_pkg::LINE_CAPACITY - 1) : k_limit;
            terminator_next     = k_end;
            line_length_next    = '0;
            cursor_next         = '0;
            longest_length_next = '0;
            active_next         = 1'b1;
          end
        end else if (!active || k_ctl) begin
          edited_next = 1'b0;
        end else if (k_key == backspace_code) begin
          if (cursor != '0 && line_length != '0) begin
            ptr_next   = cursor;
            state_next = S_SHL;
          end
        end else if (k_key == left_code) begin
          if (cursor != '0) cursor_next = cursor - LW'(1);
        end else if (k_key == right_code) begin
          if (cursor < line_length) cursor_next = cursor + LW'(1);
        end else if (k_key == terminator) begin
          ptr_next   = '0;
          state_next = S_EMIT;
        end else if (k_key < kle_pkg::PRINT_LIMIT) begin
          if (line_length < length_limit) begin
            ptr_next   = line_length;
            state_next = S_SHR;
          end
        end
      end

      // delete: store[i-1] = store[i] for i in cursor..len-1, then pad
      S_SHL: begin
        if (ptr < line_length) begin
          rd_en    = 1'b1;
          rdv_next = 1'b1;
          ptr_next = ptr + LW'(1);
        end
        if (rdv) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - AW'(1);
        end else if (ptr == line_length) begin
          wr_en            = 1'b1;
          wr_addr          = AW'(line_length - LW'(1));
          wr_data          = kle_pkg::SPACE_CHAR;
          line_length_next = line_length - LW'(1);
          cursor_next      = cursor - LW'(1);
          state_next       = S_STAT;
        end
      end

      // insert: store[i] = store[i-1] for i from len down to cursor+1
      S_SHR: begin
        if (ptr > cursor) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(ptr - LW'(1));
          rdv_next = 1'b1;
          ptr_next = ptr - LW'(1);
        end
        if (rdv) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + AW'(1);
        end else if (ptr == cursor) begin
          wr_en            = 1'b1;
          wr_addr          = cursor[AW-1:0];
          wr_data          = k_key;
          cursor_next      = cursor + LW'(1);
          line_length_next = line_length + LW'(1);
          if (line_length + LW'(1) > longest_length)
            longest_length_next = line_length + LW'(1);
          state_next       = S_STAT;
        end
      end

      // stream the line; read data waits in rdata until the result slot frees
      S_EMIT: begin
        rdv_next = rdv && !emit_move;
        if (ptr < line_length && (!rdv || emit_move)) begin
          rd_en    = 1'b1;
          rdv_next = 1'b1;
          ptr_next = ptr + LW'(1);
        end
        if (emit_move) begin
          out_load        = 1'b1;
          out_kind_next   = kle_pkg::KIND_CHAR;
          out_char_next   = rdata;
          out_edited_next = 1'b1;
          out_last_next   = 1'b0;
        end else if (!rdv && ptr == line_length && out_free) begin
          out_load        = 1'b1;
          out_kind_next   = kle_pkg::KIND_CHAR;
          out_edited_next = 1'b1;
          active_next     = 1'b0;
          state_next      = S_IDLE;
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    out_v_next = out_load ? 1'b1 : (out_v && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      line_length    <= '0;
      cursor         <= '0;
      longest_length <= '0;
      length_limit   <= '0;
      terminator     <= '0;
      active         <= 1'b0;
      ptr            <= '0;
      edited         <= 1'b0;
      rdv            <= 1'b0;
      out_v          <= 1'b0;
    end else begin
      state          <= state_next;
      line_length    <= line_length_next;
      cursor         <= cursor_next;
      longest_length <= longest_length_next;
      length_limit   <= length_limit_next;
      terminator     <= terminator_next;
      active         <= active_next;
      ptr            <= ptr_next;
      edited         <= edited_next;
      rdv            <= rdv_next;
      out_v          <= out_v_next;
    end
  end

  // status carries the lengths as they stand once the edit is done
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind   <= out_kind_next;
      out_char   <= out_char_next;
      out_edited <= out_edited_next;
      out_last   <= out_last_next;
      out_cur    <= cursor;
      out_len    <= line_length;
      out_long   <= longest_length;
    end
  end

  assign res.valid      = out_v;
  assign res.kind       = out_kind;
  assign res.char_value = out_char;
  assign res.cursor_at  = out_cur;
  assign res.text_len   = out_len;
  assign res.echo_len   = out_long;
  assign res.edited     = out_edited;
  assign res.last       = out_last;

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= line_length)
    else $error("cursor past end of line");

  a_len_in_limit: assert property (@(posedge clk) disable iff (rst)
    line_length <= length_limit)
    else $error("line longer than its limit");

  a_end_closes_read: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_kind_next == kle_pkg::KIND_CHAR && out_last_next) |=> !active)
    else $error("read still active after terminator");

  a_result_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_v && !res.ready) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule
